// File: rtl/rbgr_pkg.sv
// shared types and constants for the red-black grid relaxation block
// no dependencies
package rbgr_pkg;

    localparam int GRID_SIZE_DEF  = 64;
    localparam int CMD_FIFO_DEPTH = 4;
    localparam int RES_FIFO_DEPTH = 4;

    localparam int          ROW_W   = 6;
    localparam int          COL_W   = 6;
    localparam int          VALUE_W = 32;
    localparam int          FACTOR_W = 8;
    localparam logic [7:0]  FACTOR_RESET = 8'd1;

    // register index on the config port
    localparam logic        REG_FACTOR = 1'b0;

    // action codes of an input item
    localparam logic [1:0]  ACT_WRITE = 2'd0;
    localparam logic [1:0]  ACT_SWEEP = 2'd1;
    localparam logic [1:0]  ACT_READ  = 2'd2;

    // classified command handed from front to back
    typedef enum logic [1:0] {
        K_ZERO  = 2'd0,
        K_WRITE = 2'd1,
        K_READ  = 2'd2,
        K_SWEEP = 2'd3
    } t_kind;

    typedef struct packed {
        logic clearing;
        logic sweeping;
    } t_back_stat;

endpackage

// File: rtl/red_black_grid_relaxation.sv
// top level of the red-black grid relaxation block
// depends on rbgr_pkg, rbgr_front, rbgr_back and rbgr_fifo
//
// The block holds a GRID_SIZE x GRID_SIZE grid of signed 32-bit cells in one
// memory with a write port and a registered read port. Every item gives one
// result: the cell value for a read of a cell inside the grid, zero otherwise.
// Cell writes and reads run at one item per cycle, set by the single memory
// write and read port, while no sweep runs and the result queue has room. A
// sweep updates each interior cell in steps (four neighbor reads, sum,
// quarter, multiply and write back), with a row step per row and color;
// its zero result appears when the sweep has finished. After reset a
// clearing pass zeroes the grid while full stays high; config writes are
// taken as usual.
// relax_factor sits at byte address 0 of the config port.
module red_black_grid_relaxation #(
    parameter int GRID_SIZE = rbgr_pkg::GRID_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // item input queue side
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  i_action,
    input  logic [rbgr_pkg::ROW_W-1:0]  i_row,
    input  logic [rbgr_pkg::COL_W-1:0]  i_column,
    input  logic signed [31:0]          i_write_value,
    // result queue side
    output logic                        empty,
    input  logic                        pop,
    output logic signed [31:0]          o_read_value,
    // config port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    localparam int ADDR_W = $clog2(GRID_SIZE * GRID_SIZE);

    logic [7:0]           r_factor;
    logic                 w_cfg_wr;

    logic                 w_front_full;
    logic                 w_accept;
    logic                 w_cmd_valid;
    rbgr_pkg::t_kind      w_cmd_kind;
    logic [ADDR_W-1:0]    w_cmd_addr;
    logic [31:0]          w_cmd_value;
    logic                 w_cmd_pop;

    logic                 w_res_push;
    logic [31:0]          w_res_value;
    logic                 w_res_full, w_res_afull;
    logic [31:0]          w_res_out;
    rbgr_pkg::t_back_stat w_stat;

    // config register: one word, upper address bit picks the register index
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= rbgr_pkg::FACTOR_RESET;
        end else if (w_cfg_wr && (paddr[2] == rbgr_pkg::REG_FACTOR)) begin
            r_factor <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == rbgr_pkg::REG_FACTOR) ? {24'd0, r_factor} : '0;

    // no item is taken while the grid is being cleared
    assign full     = w_front_full || w_stat.clearing;
    assign w_accept = push && !full;

    rbgr_front #(
        .GRID_SIZE (GRID_SIZE),
        .DEPTH     (rbgr_pkg::CMD_FIFO_DEPTH),
        .ADDR_W    (ADDR_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (w_accept),
        .i_action      (i_action),
        .i_row         (i_row),
        .i_column      (i_column),
        .i_write_value (i_write_value),
        .o_full        (w_front_full),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd_kind    (w_cmd_kind),
        .o_cmd_addr    (w_cmd_addr),
        .o_cmd_value   (w_cmd_value),
        .i_cmd_pop     (w_cmd_pop)
    );

    rbgr_back #(
        .GRID_SIZE (GRID_SIZE),
        .ADDR_W    (ADDR_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd_kind  (w_cmd_kind),
        .i_cmd_addr  (w_cmd_addr),
        .i_cmd_value (w_cmd_value),
        .o_cmd_pop   (w_cmd_pop),
        .i_factor    (r_factor),
        .i_res_full  (w_res_full),
        .i_res_afull (w_res_afull),
        .o_res_push  (w_res_push),
        .o_res_value (w_res_value),
        .o_stat      (w_stat)
    );

    // result queue decouples the back end from the consumer
    rbgr_fifo #(
        .WIDTH (32),
        .DEPTH (rbgr_pkg::RES_FIFO_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_value),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty),
        .o_full  (w_res_full),
        .o_afull (w_res_afull)
    );

    assign o_read_value = w_res_out;

`ifndef SYNTHESIS
    // the back end reserves a result slot before it takes a command
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("result pushed into a full result queue");

    // a command leaves the queue only when one is waiting
    a_cmd_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd_valid)
        else $error("command popped from an empty queue");

    // a sweep shows its result only once it has finished
    a_no_result_mid_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.sweeping |-> !w_res_push)
        else $error("result pushed while a sweep is running");

    // the clearing pass keeps the input closed
    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.clearing |-> (full && !w_cmd_valid))
        else $error("item accepted during clearing pass");
`endif
endmodule

// File: rtl/rbgr_fifo.sv
// small first-in first-out queue with full and almost-full flags
// no dependencies
module rbgr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full,
    output logic             o_afull
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_afull = (r_count >= CNT_W'(DEPTH - 1));
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// File: rtl/rbgr_front.sv
// front end: classifies input items and queues commands for the back end
// depends on rbgr_pkg and rbgr_fifo
module rbgr_front #(
    parameter int GRID_SIZE = rbgr_pkg::GRID_SIZE_DEF,
    parameter int DEPTH     = rbgr_pkg::CMD_FIFO_DEPTH,
    parameter int ADDR_W    = $clog2(GRID_SIZE * GRID_SIZE)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [1:0]                  i_action,
    input  logic [rbgr_pkg::ROW_W-1:0]  i_row,
    input  logic [rbgr_pkg::COL_W-1:0]  i_column,
    input  logic signed [31:0]          i_write_value,
    output logic                        o_full,
    output logic                        o_cmd_valid,
    output rbgr_pkg::t_kind             o_cmd_kind,
    output logic [ADDR_W-1:0]           o_cmd_addr,
    output logic [31:0]                 o_cmd_value,
    input  logic                        i_cmd_pop
);
    localparam int CMD_W = $bits(rbgr_pkg::t_kind) + ADDR_W + 32;

    logic                w_inside;
    logic [ADDR_W-1:0]   w_addr;
    rbgr_pkg::t_kind     w_kind;
    logic [CMD_W-1:0]    w_in_cmd, w_out_cmd;
    logic                w_empty;
    logic                w_afull;

    assign w_inside = (32'(i_row) < 32'(GRID_SIZE)) && (32'(i_column) < 32'(GRID_SIZE));
    assign w_addr   = ADDR_W'(32'(i_row) * 32'(GRID_SIZE) + 32'(i_column));

    // outside cells fold into a plain zero result
    always_comb begin
        unique case (i_action)
            rbgr_pkg::ACT_WRITE: w_kind = w_inside ? rbgr_pkg::K_WRITE : rbgr_pkg::K_ZERO;
            rbgr_pkg::ACT_SWEEP: w_kind = rbgr_pkg::K_SWEEP;
            rbgr_pkg::ACT_READ:  w_kind = w_inside ? rbgr_pkg::K_READ : rbgr_pkg::K_ZERO;
            default:             w_kind = rbgr_pkg::K_ZERO;
        endcase
    end

    assign w_in_cmd = {w_kind, w_addr, i_write_value};

    rbgr_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_in_cmd),
        .i_pop   (i_cmd_pop),
        .o_data  (w_out_cmd),
        .o_empty (w_empty),
        .o_full  (o_full),
        .o_afull (w_afull)
    );

    assign o_cmd_valid = !w_empty;
    assign o_cmd_kind  = rbgr_pkg::t_kind'(w_out_cmd[CMD_W-1 -: $bits(rbgr_pkg::t_kind)]);
    assign o_cmd_addr  = w_out_cmd[32 +: ADDR_W];
    assign o_cmd_value = w_out_cmd[31:0];

    // almost-full is not needed on the command side
    logic w_unused;
    assign w_unused = w_afull;
endmodule

// File: rtl/rbgr_back.sv
// back end: grid memory, clearing pass, cell access and red-black sweep sequencer
// depends on rbgr_pkg
module rbgr_back #(
    parameter int GRID_SIZE = rbgr_pkg::GRID_SIZE_DEF,
    parameter int ADDR_W    = $clog2(GRID_SIZE * GRID_SIZE)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  rbgr_pkg::t_kind      i_cmd_kind,
    input  logic [ADDR_W-1:0]    i_cmd_addr,
    input  logic [31:0]          i_cmd_value,
    output logic                 o_cmd_pop,
    input  logic [7:0]           i_factor,
    input  logic                 i_res_full,
    input  logic                 i_res_afull,
    output logic                 o_res_push,
    output logic [31:0]          o_res_value,
    output rbgr_pkg::t_back_stat o_stat
);
    localparam int CELLS = GRID_SIZE * GRID_SIZE;
    localparam int CNT_W = $clog2(GRID_SIZE + 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ROW,
        S_CELL
    } t_state;

    t_state            r_state;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] r_center, r_rowbase;
    logic [CNT_W-1:0]  r_row, r_col;
    logic              r_parity;
    logic [2:0]        r_step;
    logic [31:0]       r_sum, r_quarter;
    logic              r_res_valid, r_res_is_read;

    logic [31:0]       r_mem [CELLS];
    logic [31:0]       r_rdata;

    logic              w_take;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    logic [31:0]       w_wdata;
    logic [31:0]       w_adj, w_quarter;
    logic [CNT_W-1:0]  w_start;
    logic              w_last_col;

    assign w_take = (r_state == S_IDLE) && i_cmd_valid &&
                    (r_res_valid ? !i_res_afull : !i_res_full);
    assign o_cmd_pop = w_take;

    // truncation toward zero: bias negatives by three, then shift
    assign w_adj     = r_sum + (r_sum[31] ? 32'd3 : 32'd0);
    assign w_quarter = {{2{w_adj[31]}}, w_adj[31:2]};

    // first column of the current color in this row
    assign w_start    = ((!r_row[0]) == r_parity) ? CNT_W'(1) : CNT_W'(2);
    assign w_last_col = (r_col + CNT_W'(2)) > CNT_W'(GRID_SIZE - 2);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = i_cmd_addr;
        w_wdata = i_cmd_value;
        w_raddr = i_cmd_addr;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = '0;
            end
            S_IDLE: begin
                w_we = w_take && (i_cmd_kind == rbgr_pkg::K_WRITE);
            end
            S_CELL: begin
                case (r_step[1:0])
                    2'd0:    w_raddr = r_center - ADDR_W'(GRID_SIZE);
                    2'd1:    w_raddr = r_center - ADDR_W'(1);
                    2'd2:    w_raddr = r_center + ADDR_W'(GRID_SIZE);
                    default: w_raddr = r_center + ADDR_W'(1);
                endcase
                w_we    = (r_step == 3'd6);
                w_waddr = r_center;
                w_wdata = 32'(r_quarter * {24'd0, i_factor});
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_res_valid   <= 1'b0;
            r_res_is_read <= 1'b0;
            r_parity      <= 1'b0;
            r_step        <= '0;
            r_row         <= '0;
            r_col         <= '0;
            r_center      <= '0;
            r_rowbase     <= '0;
        end else begin
            r_res_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ADDR_W'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_take) begin
                        if (i_cmd_kind == rbgr_pkg::K_SWEEP) begin
                            r_parity  <= 1'b0;
                            r_row     <= CNT_W'(1);
                            r_rowbase <= ADDR_W'(GRID_SIZE);
                            r_state   <= S_ROW;
                        end else begin
                            r_res_valid   <= 1'b1;
                            r_res_is_read <= (i_cmd_kind == rbgr_pkg::K_READ);
                        end
                    end
                end
                S_ROW: begin
                    if (r_row == CNT_W'(GRID_SIZE - 1)) begin
                        if (!r_parity) begin
                            r_parity  <= 1'b1;
                            r_row     <= CNT_W'(1);
                            r_rowbase <= ADDR_W'(GRID_SIZE);
                        end else begin
                            r_state       <= S_IDLE;
                            r_res_valid   <= 1'b1;
                            r_res_is_read <= 1'b0;
                        end
                    end else if (w_start > CNT_W'(GRID_SIZE - 2)) begin
                        r_row     <= r_row + 1'b1;
                        r_rowbase <= r_rowbase + ADDR_W'(GRID_SIZE);
                    end else begin
                        r_col    <= w_start;
                        r_center <= r_rowbase + ADDR_W'(w_start);
                        r_step   <= '0;
                        r_state  <= S_CELL;
                    end
                end
                S_CELL: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'd1) begin
                        r_sum <= r_rdata;
                    end else if (r_step >= 3'd2 && r_step <= 3'd4) begin
                        r_sum <= r_sum + r_rdata;
                    end
                    if (r_step == 3'd5) begin
                        r_quarter <= w_quarter;
                    end
                    if (r_step == 3'd6) begin
                        r_step <= '0;
                        if (w_last_col) begin
                            r_row     <= r_row + 1'b1;
                            r_rowbase <= r_rowbase + ADDR_W'(GRID_SIZE);
                            r_state   <= S_ROW;
                        end else begin
                            r_col    <= r_col + CNT_W'(2);
                            r_center <= r_center + ADDR_W'(2);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res_push  = r_res_valid;
    assign o_res_value = r_res_is_read ? r_rdata : '0;

    assign o_stat.clearing = (r_state == S_CLEAR);
    assign o_stat.sweeping = (r_state == S_ROW) || (r_state == S_CELL);
endmodule
